/* sv/contiguous_fit_allocator_top_defines.svh */
// assertion macros for the contiguous fit allocator checker
`ifndef CONTIGUOUS_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define CFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/cfa_pkg.sv */
// shared constants and control types of the contiguous fit allocator
package cfa_pkg;

  localparam int CFA_UNITS = 1024;
  localparam int CFA_SLOTS = 16;
  localparam int CFA_AW    = 10;
  localparam int CFA_CW    = 11;
  localparam int CFA_IW    = 4;

  localparam logic [CFA_AW-1:0] CFA_TOP_RST = 10'd1023;

  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_COMPACT = 2'd2;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_IN_USE = 2'd2;

  typedef struct packed {
    logic load;
    logic scan;
    logic fill;
    logic compact;
  } cfa_cmd_t;

  typedef struct packed {
    logic go_scan;
    logic go_fill;
    logic go_compact;
    logic scan_last;
    logic found;
    logic fill_last;
    logic compact_last;
  } cfa_stat_t;

endpackage

/* sv/cfa_ctrl.sv */
// controller state machine of the contiguous fit allocator
module cfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cfa_pkg::cfa_stat_t st,
  output cfa_pkg::cfa_cmd_t  cmd,
  output logic              busy,
  output logic              out_valid
);
  import cfa_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_FILL, S_COMPACT, S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.compact = 1'b1;
        if (st.compact_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (st.go_scan)         state_nxt = S_SCAN;
          else if (st.go_fill)    state_nxt = S_FILL;
          else if (st.go_compact) state_nxt = S_COMPACT;
          else                    state_nxt = S_RESP;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_last) state_nxt = st.found ? S_FILL : S_RESP;
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (st.fill_last) state_nxt = S_RESP;
      end
      S_COMPACT: begin
        cmd.compact = 1'b1;
        if (st.compact_last) state_nxt = S_RESP;
      end
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
      valid_r <= (state_nxt == S_RESP);
    end
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;

endmodule

/* sv/cfa_dp.sv */
// datapath of the contiguous fit allocator: occupancy memory, slot table, hole scan
module cfa_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfa_pkg::cfa_cmd_t           cmd,
  output cfa_pkg::cfa_stat_t          st,
  input  logic                        cfg_wr_en,
  input  logic [cfa_pkg::CFA_AW-1:0]  cfg_wr_data,
  input  logic [1:0]                  in_operation,
  input  logic [cfa_pkg::CFA_IW-1:0]  in_process_id,
  input  logic [cfa_pkg::CFA_CW-1:0]  in_request_size,
  input  logic [1:0]                  in_fit_policy,
  output logic [1:0]                  out_status,
  output logic [cfa_pkg::CFA_AW-1:0]  out_granted_start
);
  import cfa_pkg::*;

  logic                occ_mem [CFA_UNITS];
  logic                rd_data_r;

  logic [CFA_AW-1:0]   top_r;
  logic [CFA_IW-1:0]   id_r;
  logic [CFA_CW-1:0]   size_r;
  logic [1:0]          pol_r;

  logic [CFA_SLOTS-1:0] slot_valid_r;
  logic [CFA_AW-1:0]   slot_start_r [CFA_SLOTS];
  logic [CFA_CW-1:0]   slot_size_r  [CFA_SLOTS];
  logic [CFA_CW-1:0]   used_r;

  logic [CFA_CW-1:0]   addr_r, addr_d_r, cnt_r, dst_r;
  logic                rd_vld_r, fill_r;

  logic [CFA_AW-1:0]   run_start_r, run_start_nxt, best_start_r, best_start_nxt;
  logic [CFA_CW-1:0]   run_len_r, run_len_nxt, best_len_r, best_len_nxt;
  logic                found_r, found_nxt;

  logic [1:0]          status_r;
  logic [CFA_AW-1:0]   granted_r;

  logic [CFA_CW-1:0]   top_p1;
  logic                bad_req, issue, scan_bit;
  logic                mem_we, mem_wdata;
  logic [CFA_SLOTS-1:0] hit_vec;
  logic [CFA_CW-1:0]   hit_size;

  assign top_p1  = {1'b0, top_r} + CFA_CW'(1);
  assign bad_req = (in_fit_policy != FIT_FIRST && in_fit_policy != FIT_BEST &&
                    in_fit_policy != FIT_WORST) ||
                   (in_request_size == '0) || (in_request_size > top_p1);

  assign st.go_scan      = (in_operation == OP_REQUEST) && !slot_valid_r[in_process_id] &&
                           !bad_req;
  assign st.go_fill      = (in_operation == OP_RELEASE) && slot_valid_r[in_process_id];
  assign st.go_compact   = (in_operation == OP_COMPACT);
  assign st.scan_last    = rd_vld_r && (addr_d_r == top_p1);
  assign st.found        = found_nxt;
  assign st.fill_last    = (cnt_r == CFA_CW'(1));
  assign st.compact_last = (addr_r == CFA_CW'(CFA_UNITS - 1));

  assign issue    = (addr_r <= top_p1);
  // units past the top read as occupied so the last hole closes
  assign scan_bit = (addr_d_r > {1'b0, top_r}) | rd_data_r;

  // hole tracking
  always_comb begin
    run_start_nxt  = run_start_r;
    run_len_nxt    = run_len_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    found_nxt      = found_r;
    if (cmd.scan && rd_vld_r) begin
      if (!scan_bit) begin
        if (run_len_r == '0) run_start_nxt = addr_d_r[CFA_AW-1:0];
        run_len_nxt = run_len_r + CFA_CW'(1);
      end else begin
        if (run_len_r != '0 && run_len_r >= size_r &&
            (!found_r || (pol_r == FIT_BEST && run_len_r < best_len_r) ||
             (pol_r == FIT_WORST && run_len_r > best_len_r))) begin
          best_start_nxt = run_start_r;
          best_len_nxt   = run_len_r;
          found_nxt      = 1'b1;
        end
        run_len_nxt = '0;
      end
    end
  end

  // slot whose region starts at the compaction address
  always_comb begin
    hit_size = '0;
    for (int i = 0; i < CFA_SLOTS; i++) begin
      hit_vec[i] = slot_valid_r[i] && ({1'b0, slot_start_r[i]} == addr_r);
      if (hit_vec[i]) hit_size = hit_size | slot_size_r[i];
    end
  end

  assign mem_we    = cmd.fill | cmd.compact;
  assign mem_wdata = cmd.fill ? fill_r : (addr_r < used_r);

  always_ff @(posedge clk) begin
    if (mem_we) occ_mem[addr_r[CFA_AW-1:0]] <= mem_wdata;
    rd_data_r <= occ_mem[addr_r[CFA_AW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r        <= CFA_TOP_RST;
      slot_valid_r <= '0;
      used_r       <= '0;
      addr_r       <= '0;
      dst_r        <= '0;
      rd_vld_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) top_r <= cfg_wr_data;
      rd_vld_r <= cmd.scan && issue;
      if (cmd.load) begin
        addr_r <= st.go_fill ? {1'b0, slot_start_r[in_process_id]} : '0;
        dst_r  <= '0;
        if (st.go_fill) begin
          slot_valid_r[in_process_id] <= 1'b0;
          used_r <= used_r - slot_size_r[in_process_id];
        end
      end else if (cmd.scan) begin
        if (st.scan_last && found_nxt) begin
          addr_r <= {1'b0, best_start_nxt};
          slot_valid_r[id_r] <= 1'b1;
          used_r <= used_r + size_r;
        end else if (issue) begin
          addr_r <= addr_r + CFA_CW'(1);
        end
      end else if (cmd.fill) begin
        addr_r <= addr_r + CFA_CW'(1);
      end else if (cmd.compact) begin
        addr_r <= st.compact_last ? '0 : addr_r + CFA_CW'(1);
        if (hit_vec != '0) dst_r <= dst_r + hit_size;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_d_r <= addr_r;
    if (cmd.load) begin
      id_r        <= in_process_id;
      size_r      <= in_request_size;
      pol_r       <= in_fit_policy;
      run_len_r   <= '0;
      found_r     <= 1'b0;
      granted_r   <= '0;
      cnt_r       <= slot_size_r[in_process_id];
      fill_r      <= 1'b0;
      if (in_operation == OP_REQUEST && slot_valid_r[in_process_id]) status_r <= ST_IN_USE;
      else if (in_operation == OP_REQUEST && bad_req)                status_r <= ST_NO_FIT;
      else                                                           status_r <= ST_DONE;
    end else begin
      run_start_r  <= run_start_nxt;
      run_len_r    <= run_len_nxt;
      best_start_r <= best_start_nxt;
      best_len_r   <= best_len_nxt;
      found_r      <= found_nxt;
      if (cmd.scan && st.scan_last) begin
        if (found_nxt) begin
          granted_r <= best_start_nxt;
          status_r  <= ST_DONE;
          cnt_r     <= size_r;
          fill_r    <= 1'b1;
          slot_start_r[id_r] <= best_start_nxt;
          slot_size_r[id_r]  <= size_r;
        end else begin
          status_r <= ST_NO_FIT;
        end
      end
      if (cmd.fill) cnt_r <= cnt_r - CFA_CW'(1);
      if (cmd.compact) begin
        for (int i = 0; i < CFA_SLOTS; i++) begin
          if (hit_vec[i]) slot_start_r[i] <= dst_r[CFA_AW-1:0];
        end
      end
    end
  end

  assign out_status        = status_r;
  assign out_granted_start = granted_r;

endmodule

/* sv/contiguous_fit_allocator_top.sv */
// top level of the contiguous fit allocator
// Manages units 0..top_address with an occupancy bitmap and 16 process slots.
// Input: assert start with in_operation, in_process_id, in_request_size and
// in_fit_policy; the item is taken at a clock edge where start is high and busy
// is low. One result comes back per item as a one-cycle out_valid strobe with
// out_status and out_granted_start; the receiver cannot stall it.
// Steps, paced by the single port of the occupancy memory (one unit per cycle):
//   request: hole scan over units 0..top_address, then, if a hole fits,
//            marking of the granted region, then the response
//   release: clearing of the slot's region, then the response
//   compact: all 1024 units swept, then response; rejected or unknown: response
// cfg_wr_en writes top_address from cfg_wr_data; write it only while idle.
// After reset the block sweeps all 1024 units of the occupancy memory to free
// with busy high; top_address resets to 1023 and all slots are empty.
module contiguous_fit_allocator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [cfa_pkg::CFA_IW-1:0]  in_process_id,
  input  logic [cfa_pkg::CFA_CW-1:0]  in_request_size,
  input  logic [1:0]                  in_fit_policy,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [cfa_pkg::CFA_AW-1:0]  out_granted_start,
  input  logic                        cfg_wr_en,
  input  logic [cfa_pkg::CFA_AW-1:0]  cfg_wr_data
);
  import cfa_pkg::*;

  cfa_cmd_t  cmd;
  cfa_stat_t st;

  cfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  cfa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_operation      (in_operation),
    .in_process_id     (in_process_id),
    .in_request_size   (in_request_size),
    .in_fit_policy     (in_fit_policy),
    .out_status        (out_status),
    .out_granted_start (out_granted_start)
  );

endmodule

/* sv/cfa_checker.sv */
// port-level checker for the contiguous fit allocator, bound to the top level
`include "contiguous_fit_allocator_top_defines.svh"

module cfa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [1:0]                 out_status,
  input logic [cfa_pkg::CFA_AW-1:0] out_granted_start
);
  import cfa_pkg::*;

  `CFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `CFA_ASSERT_NOW(a_result_while_busy, out_valid, busy, "result shown while idle")
  `CFA_ASSERT_NEXT(a_idle_after_result, out_valid, !busy && !out_valid, "no idle after result")
  `CFA_ASSERT_NOW(a_reject_no_start, out_valid && out_status != ST_DONE,
                  out_granted_start == '0, "rejected item carries a start address")
  `CFA_ASSERT_NOW(a_status_code, out_valid, out_status == ST_DONE ||
                  out_status == ST_NO_FIT || out_status == ST_IN_USE, "bad status code")

endmodule

bind contiguous_fit_allocator_top cfa_checker u_cfa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_granted_start (out_granted_start)
);
